// File: hw/rtl/ppbeep_pkg.sv
// ----------------------------------------------------------------------------
// ppbeep_pkg
// Shared types and constants of the panned proximity beeper.
// ----------------------------------------------------------------------------
package ppbeep_pkg;

    typedef enum logic [1:0] {
        OP_OBSERVE = 2'd0,
        OP_TICK    = 2'd1,
        OP_START   = 2'd2,
        OP_STOP    = 2'd3
    } t_op;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BEEP_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_TMO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_RELOAD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_RELOAD  = 2'd3;

    // half of the reset reload value (65535 + 1) / 2
    localparam logic [15:0] HALF_RELOAD_RST = 16'd32768;

    typedef struct packed {
        logic [15:0] beep_ms;
        logic [15:0] quiet_ms;
        logic [15:0] left_half;
        logic [15:0] right_half;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [7:0]  position;
        logic [15:0] range_mm;
        logic        measure_valid;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic [15:0] left_duty;
        logic [15:0] right_duty;
        logic        tone_active;
    } t_result;

endpackage

// File: hw/rtl/ppbeep_pan.sv
// ----------------------------------------------------------------------------
// ppbeep_pan
// Pan gain scaling: half reload times gain percent, floored.
// ----------------------------------------------------------------------------
module ppbeep_pan (
    input  logic [2:0]  i_position,
    input  logic [15:0] i_left_half,
    input  logic [15:0] i_right_half,
    output logic [15:0] o_left_level,
    output logic [15:0] o_right_level
);

    // gain percent scaled by 2^22 / 100, rounded up
    localparam int unsigned FRAC_W = 22;
    localparam logic [22:0] GAIN_K [8] = '{
        23'd4194304, 23'd4068475, 23'd3774874, 23'd3271558,
        23'd2600469, 23'd1803551, 23'd922747,  23'd0
    };

    logic [38:0] w_left_prod;
    logic [38:0] w_right_prod;

    assign w_left_prod  = {23'd0, i_left_half} * {16'd0, GAIN_K[i_position]};
    assign w_right_prod = {23'd0, i_right_half} * {16'd0, GAIN_K[3'd7 - i_position]};

    assign o_left_level  = w_left_prod[FRAC_W+15:FRAC_W];
    assign o_right_level = w_right_prod[FRAC_W+15:FRAC_W];

endmodule

// File: hw/rtl/ppbeep_ctrl.sv
// ----------------------------------------------------------------------------
// ppbeep_ctrl
// Beeper state and the single-pass update for one input beat.
// ----------------------------------------------------------------------------
module ppbeep_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ppbeep_pkg::t_item   i_item,
    input  ppbeep_pkg::t_cfg    i_cfg,
    output ppbeep_pkg::t_result o_result
);

    logic        r_running,    n_running;
    logic        r_obs_pend,   n_obs_pend;
    logic [2:0]  r_pend_pos,   n_pend_pos;
    logic [15:0] r_pend_dist,  n_pend_dist;
    logic        r_pend_valid, n_pend_valid;
    logic [2:0]  r_act_pos,    n_act_pos;
    logic        r_act_valid,  n_act_valid;
    logic [3:0]  r_act_rate,   n_act_rate;
    logic [31:0] r_last_time,  n_last_time;
    logic        r_tone,       n_tone;
    logic [31:0] r_next_time,  n_next_time;
    logic [15:0] r_left,       n_left;
    logic [15:0] r_right,      n_right;

    logic [15:0] w_pan_left;
    logic [15:0] w_pan_right;
    logic [31:0] w_age;
    logic [31:0] w_since_toggle;
    logic [9:0]  w_period;
    logic [15:0] w_off;
    logic        w_mute;

    function automatic logic [3:0] rate_of(input logic [15:0] d);
        logic [3:0] r;
        if (d == 16'd0 || d > 16'd2000) r = 4'd0;
        else if (d > 16'd1500)          r = 4'd2;
        else if (d > 16'd1000)          r = 4'd3;
        else if (d > 16'd700)           r = 4'd4;
        else if (d > 16'd500)           r = 4'd6;
        else if (d > 16'd350)           r = 4'd8;
        else                            r = 4'd10;
        return r;
    endfunction

    // 1000 / rate for the nonzero rates the map can give
    function automatic logic [9:0] period_of(input logic [3:0] rate);
        logic [9:0] p;
        case (rate)
            4'd2:    p = 10'd500;
            4'd3:    p = 10'd333;
            4'd4:    p = 10'd250;
            4'd6:    p = 10'd166;
            4'd8:    p = 10'd125;
            4'd10:   p = 10'd100;
            default: p = 10'd1;
        endcase
        return p;
    endfunction

    ppbeep_pan u_pan (
        .i_position    (n_act_pos),
        .i_left_half   (i_cfg.left_half),
        .i_right_half  (i_cfg.right_half),
        .o_left_level  (w_pan_left),
        .o_right_level (w_pan_right)
    );

    assign w_age          = i_item.now_ms - n_last_time;
    assign w_since_toggle = i_item.now_ms - r_next_time;
    assign w_period       = period_of(n_act_rate);
    assign w_off          = ({6'd0, w_period} > i_cfg.beep_ms)
                          ? ({6'd0, w_period} - i_cfg.beep_ms) : 16'd0;
    assign w_mute         = !n_act_valid || (w_age > {16'd0, i_cfg.quiet_ms})
                          || (n_act_rate == 4'd0);

    // pending observation becomes active on a tick of an armed block
    always_comb begin
        n_act_pos   = r_act_pos;
        n_act_valid = r_act_valid;
        n_act_rate  = r_act_rate;
        n_last_time = r_last_time;
        if (i_item.op == ppbeep_pkg::OP_TICK && r_running && r_obs_pend) begin
            n_act_pos   = r_pend_pos;
            n_act_valid = r_pend_valid;
            n_act_rate  = r_pend_valid ? rate_of(r_pend_dist) : 4'd0;
            n_last_time = i_item.now_ms;
        end
    end

    always_comb begin
        n_running    = r_running;
        n_obs_pend   = r_obs_pend;
        n_pend_pos   = r_pend_pos;
        n_pend_dist  = r_pend_dist;
        n_pend_valid = r_pend_valid;
        n_tone       = r_tone;
        n_next_time  = r_next_time;
        n_left       = r_left;
        n_right      = r_right;

        case (i_item.op)
            ppbeep_pkg::OP_OBSERVE: begin
                n_pend_pos   = (i_item.position > 8'd7) ? 3'd7 : i_item.position[2:0];
                n_pend_dist  = i_item.range_mm;
                n_pend_valid = i_item.measure_valid;
                n_obs_pend   = 1'b1;
            end
            ppbeep_pkg::OP_TICK: begin
                if (r_running) begin
                    n_obs_pend = 1'b0;
                    if (w_mute) begin
                        n_left      = 16'd0;
                        n_right     = 16'd0;
                        n_tone      = 1'b0;
                        n_next_time = i_item.now_ms;
                    end else begin
                        // new pan takes effect at once while sounding
                        if (r_obs_pend && r_tone) begin
                            n_left  = w_pan_left;
                            n_right = w_pan_right;
                        end
                        if (!w_since_toggle[31]) begin
                            if (!r_tone) begin
                                n_left      = w_pan_left;
                                n_right     = w_pan_right;
                                n_tone      = 1'b1;
                                n_next_time = i_item.now_ms + {16'd0, i_cfg.beep_ms};
                            end else begin
                                n_left      = 16'd0;
                                n_right     = 16'd0;
                                n_tone      = 1'b0;
                                n_next_time = i_item.now_ms + {16'd0, w_off};
                            end
                        end
                    end
                end
            end
            ppbeep_pkg::OP_START: begin
                n_left      = 16'd0;
                n_right     = 16'd0;
                n_tone      = 1'b0;
                n_next_time = 32'd0;
                n_running   = 1'b1;
            end
            ppbeep_pkg::OP_STOP: begin
                n_left    = 16'd0;
                n_right   = 16'd0;
                n_tone    = 1'b0;
                n_running = 1'b0;
            end
            default: begin
                n_running = r_running;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_obs_pend   <= 1'b0;
            r_pend_pos   <= 3'd0;
            r_pend_dist  <= 16'd0;
            r_pend_valid <= 1'b0;
            r_act_pos    <= 3'd0;
            r_act_valid  <= 1'b0;
            r_act_rate   <= 4'd0;
            r_last_time  <= 32'd0;
            r_tone       <= 1'b0;
            r_next_time  <= 32'd0;
            r_left       <= 16'd0;
            r_right      <= 16'd0;
        end else if (i_fire) begin
            r_running    <= n_running;
            r_obs_pend   <= n_obs_pend;
            r_pend_pos   <= n_pend_pos;
            r_pend_dist  <= n_pend_dist;
            r_pend_valid <= n_pend_valid;
            r_act_pos    <= n_act_pos;
            r_act_valid  <= n_act_valid;
            r_act_rate   <= n_act_rate;
            r_last_time  <= n_last_time;
            r_tone       <= n_tone;
            r_next_time  <= n_next_time;
            r_left       <= n_left;
            r_right      <= n_right;
        end
    end

    assign o_result.left_duty   = n_left;
    assign o_result.right_duty  = n_right;
    assign o_result.tone_active = n_tone;

endmodule

// File: hw/rtl/panned_proximity_beeper_core.sv
// ----------------------------------------------------------------------------
// panned_proximity_beeper_core
// Two-channel proximity beeper with pan, one result beat per input beat.
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) carries op, position, distance,
//   valid flag and millisecond time; every input beat gives exactly one
//   result beat on the output channel (o_out_valid / i_out_ready) with both
//   duty compare values and the tone flag
//   each beat passes an input register, then the single-pass update
//   of the beeper state, whose result is held in the output register
//   throughput is one beat per cycle while the receiver takes results
//   a stalled receiver holds the output register; one more beat waits in the
//   input register, then o_in_ready drops until the output is taken
//   config writes (i_cfg_we) set beep length, silence timeout and both
//   reload values; write them only while no beat is in flight
//   synchronous reset clears the state: disarmed, muted, reloads 65535
// ----------------------------------------------------------------------------
module panned_proximity_beeper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_position,
    input  logic [15:0] i_range_mm,
    input  logic        i_measure_valid,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_left_duty,
    output logic [15:0] o_right_duty,
    output logic        o_tone_active,
    input  logic        i_cfg_we,
    input  logic [ppbeep_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic                r_in_vld;
    ppbeep_pkg::t_item   r_item;
    logic                r_out_vld;
    ppbeep_pkg::t_result r_out;
    ppbeep_pkg::t_cfg    r_cfg;
    ppbeep_pkg::t_result w_result;
    logic                w_fire;
    logic [16:0]         w_half;

    assign w_fire     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_fire;
    assign w_half     = ({1'b0, i_cfg_data} + 17'd1) >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.op            <= ppbeep_pkg::t_op'(i_op);
            r_item.position      <= i_position;
            r_item.range_mm      <= i_range_mm;
            r_item.measure_valid <= i_measure_valid;
            r_item.now_ms        <= i_now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beep_ms    <= 16'd0;
            r_cfg.quiet_ms   <= 16'd0;
            r_cfg.left_half  <= ppbeep_pkg::HALF_RELOAD_RST;
            r_cfg.right_half <= ppbeep_pkg::HALF_RELOAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppbeep_pkg::CFG_BEEP_LENGTH:  r_cfg.beep_ms    <= i_cfg_data;
                ppbeep_pkg::CFG_SILENCE_TMO:  r_cfg.quiet_ms   <= i_cfg_data;
                ppbeep_pkg::CFG_LEFT_RELOAD:  r_cfg.left_half  <= w_half[15:0];
                ppbeep_pkg::CFG_RIGHT_RELOAD: r_cfg.right_half <= w_half[15:0];
                default:                      r_cfg.beep_ms    <= r_cfg.beep_ms;
            endcase
        end
    end

    ppbeep_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    assign o_out_valid   = r_out_vld;
    assign o_left_duty   = r_out.left_duty;
    assign o_right_duty  = r_out.right_duty;
    assign o_tone_active = r_out.tone_active;

endmodule
